### rtl/bmdf_pkg.sv
`timescale 1ns / 1ps
package bmdf_pkg;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH       = 3'd0,
    REG_IMAGE_HEIGHT      = 3'd1,
    REG_CHANNEL_A         = 3'd2,
    REG_CHANNEL_B         = 3'd3,
    REG_BOX_A_HALF_WIDTH  = 3'd4,
    REG_BOX_A_HALF_HEIGHT = 3'd5,
    REG_BOX_B_HALF_WIDTH  = 3'd6,
    REG_BOX_B_HALF_HEIGHT = 3'd7
  } reg_idx_t;

  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned FEAT_W     = 17;
  localparam int unsigned LOAD_ADDR_W = 18;
  localparam int unsigned LOAD_VAL_W = 24;
  localparam int unsigned COORD_W    = 8;
  localparam int unsigned HALF_W     = 7;
  localparam int unsigned CH_W       = 2;
  localparam int unsigned DIM_W      = 9;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // corner order inside one evaluation: A0..A3, B0..B3
  typedef enum logic [1:0] {
    CRN_BR = 2'd0,
    CRN_BL = 2'd1,
    CRN_TR = 2'd2,
    CRN_TL = 2'd3
  } corner_t;

  typedef struct packed {
    logic                      mode;
    logic [LOAD_ADDR_W-1:0]    load_address;
    logic [LOAD_VAL_W-1:0]     load_value;
    logic [COORD_W-1:0]        pixel_x;
    logic [COORD_W-1:0]        pixel_y;
    logic signed [COORD_W-1:0] box_a_offset_x;
    logic signed [COORD_W-1:0] box_a_offset_y;
    logic signed [COORD_W-1:0] box_b_offset_x;
    logic signed [COORD_W-1:0] box_b_offset_y;
  } in_word_t;

  typedef struct packed {
    logic signed [FEAT_W-1:0] feature_value;
  } out_word_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_word_t;

endpackage

### rtl/bmdf_if.sv
`timescale 1ns / 1ps
interface bmdf_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/bmdf_ram.sv
`timescale 1ns / 1ps
module bmdf_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end
      rdata <= mem[addr];
    end
  end
endmodule

### rtl/bmdf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// Signed dividend, positive divisor; quotient truncated toward zero.
module bmdf_div #(
  parameter int unsigned NUM_W = 34,
  parameter int unsigned DEN_W = 17,
  parameter int unsigned TAG_W = 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0]        in_den,
  input  logic [TAG_W-1:0]        in_tag,
  output logic                    out_valid,
  output logic signed [NUM_W-1:0] out_quo,
  output logic [TAG_W-1:0]        out_tag
);
  localparam int unsigned MAG_W = NUM_W;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] quo;
    logic [DEN_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [TAG_W-1:0] tag;
  } dstage_t;

  logic    [MAG_W:0] vld_r;
  dstage_t           st_r [MAG_W+1];
  dstage_t           st_nxt [MAG_W];

  always_comb begin
    for (int i = 0; i < MAG_W; i++) begin
      logic [DEN_W:0] trial;
      st_nxt[i] = st_r[i];
      trial = {st_r[i].rem, st_r[i].quo[MAG_W-1]};
      st_nxt[i].quo = {st_r[i].quo[MAG_W-2:0], 1'b0};
      if (trial >= {1'b0, st_r[i].den}) begin
        st_nxt[i].rem = DEN_W'(trial - {1'b0, st_r[i].den});
        st_nxt[i].quo[0] = 1'b1;
      end else begin
        st_nxt[i].rem = trial[DEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[MAG_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r[0].neg <= in_num[NUM_W-1];
      st_r[0].quo <= in_num[NUM_W-1] ? MAG_W'(-in_num) : MAG_W'(in_num);
      st_r[0].rem <= '0;
      st_r[0].den <= in_den;
      st_r[0].tag <= in_tag;
      for (int i = 0; i < MAG_W; i++) begin
        st_r[i+1] <= st_nxt[i];
      end
    end
  end

  assign out_valid = vld_r[MAG_W];
  assign out_quo   = st_r[MAG_W].neg ? -$signed(st_r[MAG_W].quo) : $signed(st_r[MAG_W].quo);
  assign out_tag   = st_r[MAG_W].tag;
endmodule

### rtl/box_mean_difference_feature_top.sv
`timescale 1ns / 1ps
// Box mean difference feature over an interleaved multi-channel inclusive
// integral image held in one single-ported store. A load word (mode 0) writes
// one store word; words beyond the store are dropped. An evaluate word (mode 1)
// clamps both boxes and reads all eight corners through the single store port,
// one per cycle while the pipe is not stalled, so the next evaluate word is
// taken only once the sequencer leaves its busy state; a load word that follows
// an evaluate also waits through the tail step, because the last corner read
// still holds the port. Both box sums then pass through a pipelined bit-per-stage
// divider and one feature word comes back. Evaluations overlap in the divider.
// A result that waits on out_ch freezes the whole pipe. Configure only while
// the block is idle.
module box_mean_difference_feature_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned CHANNELS   = 3,
  parameter int unsigned SUM_BITS   = 24
) (
  input logic clk,
  input logic rst_n,
  bmdf_if.sink   in_ch,
  bmdf_if.sink   cfg_ch,
  bmdf_if.source out_ch
);
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned XW     = $clog2(MAX_WIDTH + 1) + 1;
  localparam int unsigned YW     = $clog2(MAX_HEIGHT + 1) + 1;
  localparam int unsigned CLW    = ((XW > YW) ? XW : YW) + 2;
  localparam int unsigned CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned AREA_W = (XW - 1) + (YW - 1);
  localparam int unsigned BS_W   = SUM_BITS + 2;
  localparam int unsigned NUM_W  = BS_W + 9;
  localparam int          QSAT   = 65535;

  // ---------------- configuration ----------------
  logic [bmdf_pkg::DIM_W-1:0]  width_r, height_r;
  logic [bmdf_pkg::CH_W-1:0]   cha_r, chb_r;
  logic [bmdf_pkg::HALF_W-1:0] ahw_r, ahh_r, bhw_r, bhh_r;
  bmdf_pkg::cfg_word_t         cw;

  assign cw           = cfg_ch.data;
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
      cha_r <= '0; chb_r <= '0;
      ahw_r <= '0; ahh_r <= '0; bhw_r <= '0; bhh_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (bmdf_pkg::reg_idx_t'(cw.index))
        bmdf_pkg::REG_IMAGE_WIDTH:       width_r  <= cw.data;
        bmdf_pkg::REG_IMAGE_HEIGHT:      height_r <= cw.data;
        bmdf_pkg::REG_CHANNEL_A:         cha_r <= cw.data[1:0];
        bmdf_pkg::REG_CHANNEL_B:         chb_r <= cw.data[1:0];
        bmdf_pkg::REG_BOX_A_HALF_WIDTH:  ahw_r <= cw.data[6:0];
        bmdf_pkg::REG_BOX_A_HALF_HEIGHT: ahh_r <= cw.data[6:0];
        bmdf_pkg::REG_BOX_B_HALF_WIDTH:  bhw_r <= cw.data[6:0];
        bmdf_pkg::REG_BOX_B_HALF_HEIGHT: bhh_r <= cw.data[6:0];
        default: ;
      endcase
    end
  end

  // effective (clamped) settings
  logic signed [XW-1:0] w_eff;
  logic signed [YW-1:0] h_eff;
  logic [CW-1:0]        ca_eff, cb_eff;

  always_comb begin
    if (width_r == '0) w_eff = XW'(1);
    else if (32'(width_r) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(width_r);
    if (height_r == '0) h_eff = YW'(1);
    else if (32'(height_r) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(height_r);
    ca_eff = (32'(cha_r) >= CHANNELS) ? CW'(CHANNELS - 1) : CW'(cha_r);
    cb_eff = (32'(chb_r) >= CHANNELS) ? CW'(CHANNELS - 1) : CW'(chb_r);
  end

  // ---------------- stage 1: box clamp ----------------
  bmdf_pkg::in_word_t iw;
  assign iw = in_ch.data;

  typedef struct packed {
    logic [XW-2:0] x1, x2;
    logic [YW-2:0] y1, y2;
  } box_t;

  function automatic box_t clamp_box(input logic [7:0] p_x, input logic [7:0] p_y,
                                     input logic signed [7:0] o_x,
                                     input logic signed [7:0] o_y,
                                     input logic [6:0] hw, input logic [6:0] hh,
                                     input logic signed [XW-1:0] w,
                                     input logic signed [YW-1:0] h);
    logic signed [CLW-1:0] cx, cy, a, b, c, d, wm, hm;
    box_t r;
    cx = $signed(CLW'(p_x)) + CLW'(o_x);
    cy = $signed(CLW'(p_y)) + CLW'(o_y);
    wm = CLW'(w) - CLW'(1);
    hm = CLW'(h) - CLW'(1);
    a = cx - $signed(CLW'(hw));
    b = cx + $signed(CLW'(hw));
    c = cy - $signed(CLW'(hh));
    d = cy + $signed(CLW'(hh));
    r.x1 = (a < 0) ? '0 : (a > wm) ? (XW-1)'(wm) : (XW-1)'(a);
    r.x2 = (b < 0) ? '0 : (b > wm) ? (XW-1)'(wm) : (XW-1)'(b);
    r.y1 = (c < 0) ? '0 : (c > hm) ? (YW-1)'(hm) : (YW-1)'(c);
    r.y2 = (d < 0) ? '0 : (d > hm) ? (YW-1)'(hm) : (YW-1)'(d);
    return r;
  endfunction

  // ---------------- corner sequencer ----------------
  // One evaluate item holds the store port for all its corner reads; a load uses it once.
  logic          busy_r;
  logic          tail_r;
  logic [2:0]    step_r;
  box_t          ba_r, bb_r;
  logic [CW-1:0] ca_r, cb_r;
  logic          stall;
  logic          in_take;

  // tail cycle overlaps the next input acceptance: block loads then
  assign in_ch.ready = rst_n && !stall && !busy_r &&
                       !(tail_r && iw.mode == bmdf_pkg::MODE_LOAD);
  assign in_take     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (!stall) begin
      if (in_take && iw.mode == bmdf_pkg::MODE_EVAL) begin
        busy_r <= 1'b1;
        step_r <= 3'd1;
      end else if (busy_r) begin
        step_r <= 3'(step_r + 3'd1);
        if (step_r == 3'd7) busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && in_take) begin
      ba_r <= clamp_box(iw.pixel_x, iw.pixel_y, iw.box_a_offset_x, iw.box_a_offset_y,
                        ahw_r, ahh_r, w_eff, h_eff);
      bb_r <= clamp_box(iw.pixel_x, iw.pixel_y, iw.box_b_offset_x, iw.box_b_offset_y,
                        bhw_r, bhh_r, w_eff, h_eff);
      ca_r <= ca_eff;
      cb_r <= cb_eff;
    end
  end

  // address generation: step 0 is the cycle the word arrives (box not yet
  // registered), so corner k is issued at step k+1 with k=0..7 wrapping at 0
  logic            rd_go;
  logic [2:0]      crn;
  box_t            bx;
  logic [CW-1:0]   bch;
  logic [XW-2:0]   rx;
  logic [YW-2:0]   ry;
  logic            use_c;
  logic [AW+1:0]   pix_lin;
  logic [AW-1:0]   ram_addr;
  logic            ram_we;

  // evaluation issues corners at steps 1..7 plus a trailing tail at step 0
  always_ff @(posedge clk) begin
    if (!rst_n) tail_r <= 1'b0;
    else if (!stall) tail_r <= busy_r && step_r == 3'd7;
  end

  // corners: 0..3 box A, 4..7 box B; issue corner (step_r - 1), tail issues 7
  always_comb begin
    crn   = tail_r ? 3'd7 : 3'(step_r - 3'd1);
    rd_go = busy_r || tail_r;
    bx    = crn[2] ? bb_r : ba_r;
    bch   = crn[2] ? cb_r : ca_r;
    unique case (bmdf_pkg::corner_t'(crn[1:0]))
      bmdf_pkg::CRN_BR: begin rx = bx.x2; ry = bx.y2; use_c = 1'b1; end
      bmdf_pkg::CRN_BL: begin
        rx = (XW-1)'(bx.x1 - 1'b1); ry = bx.y2; use_c = bx.x1 != '0;
      end
      bmdf_pkg::CRN_TR: begin
        rx = bx.x2; ry = (YW-1)'(bx.y1 - 1'b1); use_c = bx.y1 != '0;
      end
      bmdf_pkg::CRN_TL: begin
        rx = (XW-1)'(bx.x1 - 1'b1); ry = (YW-1)'(bx.y1 - 1'b1);
        use_c = bx.x1 != '0 && bx.y1 != '0;
      end
      default: begin rx = bx.x2; ry = bx.y2; use_c = 1'b1; end
    endcase
    pix_lin  = (AW+2)'(ry * (XW-1)'(w_eff) + rx);
    ram_we   = !rd_go && in_take && iw.mode == bmdf_pkg::MODE_LOAD &&
               32'(iw.load_address) < DEPTH;
    ram_addr = rd_go ? AW'(pix_lin * CHANNELS + bch) : AW'(iw.load_address);
  end

  logic [SUM_BITS-1:0] rdata;
  bmdf_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .en    (!stall),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (SUM_BITS'(iw.load_value)),
    .rdata (rdata)
  );

  // read-return tracking
  logic       rv_r, ruse_r;
  logic [2:0] rcrn_r;
  box_t       rba_r, rbb_r;
  always_ff @(posedge clk) begin
    if (!rst_n) rv_r <= 1'b0;
    else if (!stall) rv_r <= rd_go;
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      ruse_r <= use_c;
      rcrn_r <= crn;
      if (rd_go && crn == 3'd0) begin
        rba_r <= ba_r;
        rbb_r <= bb_r;
      end
    end
  end

  // accumulate corners into two box sums
  logic signed [BS_W-1:0] acc_r, suma_r;
  logic signed [BS_W-1:0] term, acc_nxt;
  logic                   sv_r;
  logic signed [BS_W-1:0] sumb_r;
  box_t                   sba_r, sbb_r;

  always_comb begin
    term = ruse_r ? $signed(BS_W'(rdata)) : '0;
    unique case (bmdf_pkg::corner_t'(rcrn_r[1:0]))
      bmdf_pkg::CRN_BR: acc_nxt = term;
      bmdf_pkg::CRN_BL: acc_nxt = acc_r - term;
      bmdf_pkg::CRN_TR: acc_nxt = acc_r - term;
      bmdf_pkg::CRN_TL: acc_nxt = acc_r + term;
      default:          acc_nxt = term;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else if (!stall) sv_r <= rv_r && rcrn_r == 3'd7;
  end
  always_ff @(posedge clk) begin
    if (!stall && rv_r) begin
      acc_r <= acc_nxt;
      if (rcrn_r == 3'd3) begin
        suma_r <= acc_nxt;
        sba_r  <= rba_r;
        sbb_r  <= rbb_r;
      end
      if (rcrn_r == 3'd7) sumb_r <= acc_nxt;
    end
  end

  // ---------------- area and divide ----------------
  // both boxes enter one shared divider on consecutive enabled cycles (A then B)
  logic                   dv_r, dsel_r;
  logic signed [NUM_W-1:0] dnum_r;
  logic [AREA_W-1:0]      dden_r;
  logic signed [BS_W-1:0] pend_sum_r;
  logic [AREA_W-1:0]      pend_area_r;
  logic                   pend_r;

  function automatic logic [AREA_W-1:0] box_area(input box_t b);
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;
    dx = XW'(b.x2 - b.x1) + XW'(1);
    dy = YW'(b.y2 - b.y1) + YW'(1);
    return AREA_W'(dx * dy);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r   <= 1'b0;
      pend_r <= 1'b0;
    end else if (!stall) begin
      dv_r   <= sv_r || pend_r;
      pend_r <= sv_r;
    end
  end
  always_ff @(posedge clk) begin
    if (!stall) begin
      if (sv_r) begin
        dnum_r      <= NUM_W'(suma_r) <<< 8;
        dden_r      <= box_area(sba_r);
        dsel_r      <= 1'b0;
        pend_sum_r  <= sumb_r;
        pend_area_r <= box_area(sbb_r);
      end else begin
        dnum_r <= NUM_W'(pend_sum_r) <<< 8;
        dden_r <= pend_area_r;
        dsel_r <= 1'b1;
      end
    end
  end

  logic                    qv;
  logic signed [NUM_W-1:0] quo;
  logic                    qsel;
  bmdf_div #(.NUM_W(NUM_W), .DEN_W(AREA_W), .TAG_W(1)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (!stall),
    .in_valid  (dv_r),
    .in_num    (dnum_r),
    .in_den    (dden_r),
    .in_tag    (dsel_r),
    .out_valid (qv),
    .out_quo   (quo),
    .out_tag   (qsel)
  );

  // difference and saturation
  logic signed [NUM_W-1:0] qa_r;
  logic signed [NUM_W:0]   diff;
  logic                    ov_r;
  logic signed [bmdf_pkg::FEAT_W-1:0] ofeat_r;

  assign diff = (NUM_W+1)'(qa_r) - (NUM_W+1)'(quo);

  always_ff @(posedge clk) begin
    if (!stall && qv && !qsel) qa_r <= quo;
  end

  // output register; the whole pipe freezes while a result waits
  assign stall = ov_r && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (!stall) begin
      ov_r <= qv && qsel;
    end
  end
  always_ff @(posedge clk) begin
    if (!stall && qv && qsel) begin
      if (diff > (NUM_W+1)'(QSAT)) ofeat_r <= bmdf_pkg::FEAT_W'(QSAT);
      else if (diff < -(NUM_W+1)'(QSAT)) ofeat_r <= -bmdf_pkg::FEAT_W'(QSAT);
      else ofeat_r <= bmdf_pkg::FEAT_W'(diff);
    end
  end

  bmdf_pkg::out_word_t ow;
  assign ow.feature_value = ofeat_r;
  assign out_ch.valid     = ov_r;
  assign out_ch.data      = ow;

  // ---------------- checks ----------------
  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    rd_go |-> !ram_we) else $error("store write during corner reads");
  a_seq_span: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && step_r == 3'd7 && !stall) |=> tail_r)
    else $error("corner sequence cut short");
  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (sv_r && !stall) |=> pend_r) else $error("box B divide lost");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> ov_r && $stable(ofeat_r)) else $error("held result changed");
endmodule
